// ===== hw/rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and tables for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

	// encoder and fixed-point constants
	localparam int TICKS_PER_TURN = 400;
	localparam int TICK_SHIFT     = 13;
	localparam int HEAD_SHIFT     = 17;
	localparam int POS_FRAC       = 16;
	localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

	// CORDIC
	localparam int CORDIC_STEPS = 28;
	localparam int TRIG_W       = 33;
	localparam int ANG_W        = 32;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	// serial multiplier: 52 x 32 -> 84
	localparam int MCAND_W = 52;
	localparam int MPLR_W  = 32;
	localparam int PROD_W  = MCAND_W + MPLR_W;

	// serial divider: 71-bit dividend, 21-bit divisor
	localparam int DIV_W  = PROD_W - TICK_SHIFT;
	localparam int DVSR_W = 21;

	// distances and accumulators
	localparam int DIST_W = 47;
	localparam int ACC_W  = 48;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// configuration registers
	localparam int RADIUS_W  = 20;
	localparam int TRACK_W   = 21;
	localparam int CFG_W     = 21;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK        = 1'b1;
	localparam logic [RADIUS_W-1:0]  RADIUS_RESET     = 20'd35000;
	localparam logic [TRACK_W-1:0]   TRACK_RESET      = 21'd150000;

	// operation codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SET    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RAD,
		ST_MUL_K,
		ST_DIV_WHEEL,
		ST_PREP,
		ST_MUL_TRIG,
		ST_ACC,
		ST_MUL_HEAD,
		ST_DIV_HEAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] right_count;
		logic signed [31:0] left_count;
		logic signed [31:0] new_x_um;
		logic signed [31:0] new_y_um;
		logic        [31:0] new_heading;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x_um;
		logic signed [31:0] pos_y_um;
		logic        [31:0] heading;
	} out_t;

	// arctangent of 2^-i, binary angle with 2^32 units per turn
	function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/differential_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose tracker for a two-wheel robot. Each input transaction
// either updates the pose from absolute right/left encoder counts or loads a
// new x, y and heading, and yields one output transaction with the pose.
// Position is kept in micrometres with 16 fraction bits and saturates;
// heading is a wrapping 32-bit binary angle. A set-position input goes
// straight to the output state. An encoder update runs the bit-serial units
// in sequence: two multiplier passes for the wheel distances, a divider pass
// by the tick count, operand prep, a pass for the cos/sin scaling, an
// accumulate step, a multiplier pass and a divider pass for the heading step,
// and an output load. The CORDIC runs beside the first passes. The next
// input is taken once the result has been loaded into the output register.
// One transaction is worked on at a time; a finished result waits in the
// output register while the next transaction is taken. If that result is
// still waiting when the next one is done, the core holds until the output
// transaction is accepted.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ddo_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ddo_pkg::out_t                    out_data,
	input  logic                             cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ddo_pkg::CFG_W-1:0]        cfg_data
);

	localparam int AW = ddo_pkg::ACC_W;

	// configuration and pose state
	logic [ddo_pkg::RADIUS_W-1:0]  radius_q;
	logic [ddo_pkg::TRACK_W-1:0]   track_q;
	logic signed [AW-1:0]          x_acc_q;
	logic signed [AW-1:0]          y_acc_q;
	logic [31:0]                   head_q;
	logic [31:0]                   prev_r_q;
	logic [31:0]                   prev_l_q;
	ddo_pkg::state_t               state_q;
	ddo_pkg::state_t               state_d;
	logic                          out_valid_q;
	ddo_pkg::out_t                 out_data_q;

	// per-transaction working registers
	logic                          neg_r_q;
	logic                          neg_l_q;
	logic signed [AW-1:0]          dr_q;
	logic signed [AW-1:0]          dl_q;
	logic                          neg_x_q;
	logic                          neg_y_q;
	logic [AW-1:0]                 diff_mag_q;
	logic                          diff_neg_q;

	logic                          in_fire;
	logic                          out_load;
	logic [31:0]                   delta_r;
	logic [31:0]                   delta_l;
	logic [31:0]                   mag_r;
	logic [31:0]                   mag_l;

	logic                          mul_start;
	logic [ddo_pkg::MCAND_W-1:0]   mcand_a;
	logic [ddo_pkg::MCAND_W-1:0]   mcand_b;
	logic [ddo_pkg::MPLR_W-1:0]    mplr_a;
	logic [ddo_pkg::MPLR_W-1:0]    mplr_b;
	logic [ddo_pkg::PROD_W-1:0]    prod_a;
	logic [ddo_pkg::PROD_W-1:0]    prod_b;
	logic                          mul_done_a;
	logic                          mul_done_b;

	logic                          div_start_a;
	logic                          div_start_b;
	logic [ddo_pkg::DIV_W-1:0]     dividend_a;
	logic [ddo_pkg::DVSR_W-1:0]    divisor_a;
	logic [ddo_pkg::DIV_W-1:0]     quot_a;
	logic [ddo_pkg::DIV_W-1:0]     quot_b;
	logic                          div_done_a;
	logic                          div_done_b;

	logic                          cordic_start;
	logic                          cordic_busy;
	logic signed [ddo_pkg::TRIG_W-1:0] cos_v;
	logic signed [ddo_pkg::TRIG_W-1:0] sin_v;
	logic [ddo_pkg::TRIG_W-1:0]    cos_neg;
	logic [ddo_pkg::TRIG_W-1:0]    sin_neg;
	logic [31:0]                   cos_abs;
	logic [31:0]                   sin_abs;

	logic signed [AW:0]            wsum;
	logic signed [AW:0]            dc_full;
	logic signed [AW:0]            wdiff;
	logic [AW:0]                   wdiff_neg;
	logic [AW-1:0]                 dc_neg_v;
	logic [ddo_pkg::DIST_W-1:0]    dm;
	logic [ddo_pkg::TRACK_W-1:0]   track_eff;

	logic [AW:0]                   step_mag_x;
	logic [AW:0]                   step_mag_y;
	logic [31:0]                   hstep_mag;

	// saturate a wheel quotient and apply the sign
	function automatic logic signed [AW-1:0] wheel_dist(
		input logic [ddo_pkg::DIV_W-1:0] q,
		input logic                      neg
	);
		logic [ddo_pkg::DIST_W-1:0] mag;
		logic [AW-1:0]              pos;
		mag = (|q[ddo_pkg::DIV_W-1:ddo_pkg::DIST_W]) ? {ddo_pkg::DIST_W{1'b1}}
			: q[ddo_pkg::DIST_W-1:0];
		pos = {1'b0, mag};
		return neg ? signed'(-pos) : signed'(pos);
	endfunction

	// add a signed position step to an accumulator with saturation
	function automatic logic signed [AW-1:0] acc_add(
		input logic signed [AW-1:0] acc,
		input logic [AW:0]          smag,
		input logic                 neg
	);
		logic signed [AW+1:0] stp;
		logic signed [AW+2:0] s;
		stp = neg ? -signed'({1'b0, smag}) : signed'({1'b0, smag});
		s = {{3{acc[AW-1]}}, acc} + {stp[AW+1], stp};
		if (s[AW+2:AW-1] == {4{s[AW+2]}}) begin
			return s[AW-1:0];
		end
		return s[AW+2] ? ddo_pkg::ACC_MIN : ddo_pkg::ACC_MAX;
	endfunction

	assign in_ready = (state_q == ddo_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ddo_pkg::ST_OUT) && (!out_valid_q || out_ready);

	// encoder deltas wrap modulo 2^32
	assign delta_r = in_data.right_count - prev_r_q;
	assign delta_l = in_data.left_count - prev_l_q;
	assign mag_r   = delta_r[31] ? (32'd0 - delta_r) : delta_r;
	assign mag_l   = delta_l[31] ? (32'd0 - delta_l) : delta_l;

	// trig magnitudes
	assign cos_neg = -cos_v;
	assign sin_neg = -sin_v;
	assign cos_abs = cos_v[ddo_pkg::TRIG_W-1] ? cos_neg[31:0] : cos_v[31:0];
	assign sin_abs = sin_v[ddo_pkg::TRIG_W-1] ? sin_neg[31:0] : sin_v[31:0];

	// mean distance truncated toward zero, and wheel difference
	assign wsum      = {dr_q[AW-1], dr_q} + {dl_q[AW-1], dl_q};
	assign dc_full   = (wsum + signed'({{AW{1'b0}}, wsum[AW]})) >>> 1;
	assign dc_neg_v  = -dc_full[AW-1:0];
	assign dm        = dc_full[AW-1] ? dc_neg_v[ddo_pkg::DIST_W-1:0]
		: dc_full[ddo_pkg::DIST_W-1:0];
	assign wdiff     = {dr_q[AW-1], dr_q} - {dl_q[AW-1], dl_q};
	assign wdiff_neg = -wdiff;

	assign track_eff = (track_q == '0) ? ddo_pkg::TRACK_W'(1) : track_q;

	// scaled products
	assign step_mag_x = prod_a[AW+30:30];
	assign step_mag_y = prod_b[AW+30:30];
	assign hstep_mag  = quot_a[31:0];

	// multiplier operand select
	always_comb begin
		mul_start = 1'b0;
		mcand_a   = '0;
		mcand_b   = '0;
		mplr_a    = '0;
		mplr_b    = '0;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				if (in_fire && (in_data.operation == ddo_pkg::OP_UPDATE)) begin
					mul_start = 1'b1;
					mcand_a   = ddo_pkg::MCAND_W'(mag_r);
					mcand_b   = ddo_pkg::MCAND_W'(mag_l);
					mplr_a    = ddo_pkg::MPLR_W'(radius_q);
					mplr_b    = ddo_pkg::MPLR_W'(radius_q);
				end
			end
			ddo_pkg::ST_MUL_RAD: begin
				if (mul_done_a) begin
					mul_start = 1'b1;
					mcand_a   = prod_a[ddo_pkg::MCAND_W-1:0];
					mcand_b   = prod_b[ddo_pkg::MCAND_W-1:0];
					mplr_a    = ddo_pkg::TWO_PI_Q29;
					mplr_b    = ddo_pkg::TWO_PI_Q29;
				end
			end
			ddo_pkg::ST_PREP: begin
				mul_start = 1'b1;
				mcand_a   = ddo_pkg::MCAND_W'(dm);
				mcand_b   = ddo_pkg::MCAND_W'(dm);
				mplr_a    = cos_abs;
				mplr_b    = sin_abs;
			end
			ddo_pkg::ST_ACC: begin
				mul_start = 1'b1;
				mcand_a   = ddo_pkg::MCAND_W'(diff_mag_q);
				mcand_b   = ddo_pkg::MCAND_W'(diff_mag_q);
				mplr_a    = ddo_pkg::INV_TWO_PI_Q32;
				mplr_b    = ddo_pkg::INV_TWO_PI_Q32;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// divider operand select
	always_comb begin
		div_start_a = 1'b0;
		div_start_b = 1'b0;
		dividend_a  = prod_a[ddo_pkg::PROD_W-1:ddo_pkg::TICK_SHIFT];
		divisor_a   = ddo_pkg::DVSR_W'(ddo_pkg::TICKS_PER_TURN);
		case (state_q)
			ddo_pkg::ST_MUL_K: begin
				div_start_a = mul_done_a;
				div_start_b = mul_done_a;
			end
			ddo_pkg::ST_MUL_HEAD: begin
				div_start_a = mul_done_a;
				dividend_a  = ddo_pkg::DIV_W'(prod_a[ddo_pkg::PROD_W-1:ddo_pkg::HEAD_SHIFT]);
				divisor_a   = track_eff;
			end
			default: begin
				div_start_a = 1'b0;
			end
		endcase
	end

	assign cordic_start = in_fire && (in_data.operation == ddo_pkg::OP_UPDATE);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (in_data.operation == ddo_pkg::OP_SET)
						? ddo_pkg::ST_OUT : ddo_pkg::ST_MUL_RAD;
				end
			end
			ddo_pkg::ST_MUL_RAD: begin
				if (mul_done_a) state_d = ddo_pkg::ST_MUL_K;
			end
			ddo_pkg::ST_MUL_K: begin
				if (mul_done_a) state_d = ddo_pkg::ST_DIV_WHEEL;
			end
			ddo_pkg::ST_DIV_WHEEL: begin
				if (div_done_a) state_d = ddo_pkg::ST_PREP;
			end
			ddo_pkg::ST_PREP: begin
				state_d = ddo_pkg::ST_MUL_TRIG;
			end
			ddo_pkg::ST_MUL_TRIG: begin
				if (mul_done_a) state_d = ddo_pkg::ST_ACC;
			end
			ddo_pkg::ST_ACC: begin
				state_d = ddo_pkg::ST_MUL_HEAD;
			end
			ddo_pkg::ST_MUL_HEAD: begin
				if (mul_done_a) state_d = ddo_pkg::ST_DIV_HEAD;
			end
			ddo_pkg::ST_DIV_HEAD: begin
				if (div_done_a) state_d = ddo_pkg::ST_OUT;
			end
			ddo_pkg::ST_OUT: begin
				if (out_load) state_d = ddo_pkg::ST_IDLE;
			end
			default: begin
				state_d = ddo_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, pose and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= ddo_pkg::RADIUS_RESET;
			track_q     <= ddo_pkg::TRACK_RESET;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			head_q      <= '0;
			prev_r_q    <= '0;
			prev_l_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ddo_pkg::REG_WHEEL_RADIUS: radius_q <= cfg_data[ddo_pkg::RADIUS_W-1:0];
					ddo_pkg::REG_TRACK:        track_q  <= cfg_data[ddo_pkg::TRACK_W-1:0];
					default:                   track_q  <= track_q;
				endcase
			end
			// set position or capture new encoder references
			if (in_fire) begin
				if (in_data.operation == ddo_pkg::OP_SET) begin
					x_acc_q <= {in_data.new_x_um, {ddo_pkg::POS_FRAC{1'b0}}};
					y_acc_q <= {in_data.new_y_um, {ddo_pkg::POS_FRAC{1'b0}}};
					head_q  <= in_data.new_heading;
				end else begin
					prev_r_q <= in_data.right_count;
					prev_l_q <= in_data.left_count;
				end
			end
			// position step
			if (state_q == ddo_pkg::ST_ACC) begin
				x_acc_q <= acc_add(x_acc_q, step_mag_x, neg_x_q);
				y_acc_q <= acc_add(y_acc_q, step_mag_y, neg_y_q);
			end
			// heading step wraps
			if ((state_q == ddo_pkg::ST_DIV_HEAD) && div_done_a) begin
				head_q <= head_q + (diff_neg_q ? (32'd0 - hstep_mag) : hstep_mag);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			neg_r_q <= delta_r[31];
			neg_l_q <= delta_l[31];
		end
		if ((state_q == ddo_pkg::ST_DIV_WHEEL) && div_done_a) begin
			dr_q <= wheel_dist(quot_a, neg_r_q);
			dl_q <= wheel_dist(quot_b, neg_l_q);
		end
		if (state_q == ddo_pkg::ST_PREP) begin
			neg_x_q    <= dc_full[AW-1] ^ cos_v[ddo_pkg::TRIG_W-1];
			neg_y_q    <= dc_full[AW-1] ^ sin_v[ddo_pkg::TRIG_W-1];
			diff_neg_q <= wdiff[AW];
			diff_mag_q <= wdiff[AW] ? wdiff_neg[AW-1:0] : wdiff[AW-1:0];
		end
		if (out_load) begin
			out_data_q.pos_x_um <= x_acc_q[AW-1:ddo_pkg::POS_FRAC];
			out_data_q.pos_y_um <= y_acc_q[AW-1:ddo_pkg::POS_FRAC];
			out_data_q.heading  <= head_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// right wheel / x lane multiplier
	ddo_serial_mul u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mcand_a),
		.mplr   (mplr_a),
		.prod   (prod_a),
		.done   (mul_done_a)
	);

	// left wheel / y lane multiplier
	ddo_serial_mul u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mcand_b),
		.mplr   (mplr_b),
		.prod   (prod_b),
		.done   (mul_done_b)
	);

	// right wheel and heading divider
	ddo_serial_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_a),
		.dividend (dividend_a),
		.divisor  (divisor_a),
		.quot     (quot_a),
		.done     (div_done_a)
	);

	// left wheel divider
	ddo_serial_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_b),
		.dividend (prod_b[ddo_pkg::PROD_W-1:ddo_pkg::TICK_SHIFT]),
		.divisor  (ddo_pkg::DVSR_W'(ddo_pkg::TICKS_PER_TURN)),
		.quot     (quot_b),
		.done     (div_done_b)
	);

	// cos/sin of the heading before this update
	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (head_q),
		.cos_out (cos_v),
		.sin_out (sin_v),
		.busy    (cordic_busy)
	);

`ifndef NO_ASSERTIONS
	// both lanes start together, so they finish together
	a_mul_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_a == mul_done_b)
		else $error("multiplier lanes out of step");

	a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddo_pkg::ST_DIV_WHEEL) |-> (div_done_a == div_done_b))
		else $error("wheel dividers out of step");

	// trig results must be settled before the scaling pass reads them
	a_cordic_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddo_pkg::ST_PREP) |-> !cordic_busy)
		else $error("CORDIC still busy at scaling");

	a_set_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_data.operation == ddo_pkg::OP_SET)) |=> (state_q == ddo_pkg::ST_OUT))
		else $error("set position did not go to output");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_a |-> ((state_q == ddo_pkg::ST_DIV_WHEEL) || (state_q == ddo_pkg::ST_DIV_HEAD)))
		else $error("divider finished outside a divide step");
`endif

endmodule

// ===== hw/rtl/ddo_serial_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, 52 x 32 unsigned.
// ----------------------------------------------------------------------------
module ddo_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ddo_pkg::MCAND_W-1:0]   mcand,
	input  logic [ddo_pkg::MPLR_W-1:0]    mplr,
	output logic [ddo_pkg::PROD_W-1:0]    prod,
	output logic                          done
);

	localparam logic [4:0] LAST = 5'(ddo_pkg::MPLR_W - 1);

	logic                         busy_q;
	logic [4:0]                   cnt_q;
	logic                         done_q;
	logic [ddo_pkg::MCAND_W-1:0]  mcand_q;
	logic [ddo_pkg::PROD_W-1:0]   prod_q;
	logic [ddo_pkg::MCAND_W:0]    sum;

	// add multiplicand into the upper half when the current bit is set
	assign sum = {1'b0, prod_q[ddo_pkg::PROD_W-1:ddo_pkg::MPLR_W]}
		+ {1'b0, (prod_q[0] ? mcand_q : {ddo_pkg::MCAND_W{1'b0}})};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// product register, multiplier shifts out at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {{ddo_pkg::MCAND_W{1'b0}}, mplr};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[ddo_pkg::MPLR_W-1:1]};
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/ddo_serial_div.sv =====
// ----------------------------------------------------------------------------
// ddo_serial_div
// Restoring divider, one quotient bit per cycle, 71-bit dividend.
// ----------------------------------------------------------------------------
module ddo_serial_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ddo_pkg::DIV_W-1:0]    dividend,
	input  logic [ddo_pkg::DVSR_W-1:0]   divisor,
	output logic [ddo_pkg::DIV_W-1:0]    quot,
	output logic                         done
);

	localparam logic [6:0] LAST = 7'(ddo_pkg::DIV_W - 1);

	logic                         busy_q;
	logic [6:0]                   cnt_q;
	logic                         done_q;
	logic [ddo_pkg::DVSR_W-1:0]   dvsr_q;
	logic [ddo_pkg::DVSR_W-1:0]   rem_q;
	logic [ddo_pkg::DIV_W-1:0]    quo_q;
	logic [ddo_pkg::DVSR_W:0]     trial;
	logic [ddo_pkg::DVSR_W:0]     diff;
	logic                         ge;

	// shift next dividend bit into remainder and try the subtract
	assign trial = {rem_q, quo_q[ddo_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = trial >= {1'b0, dvsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits enter the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvsr_q <= divisor;
			rem_q  <= '0;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ddo_pkg::DVSR_W-1:0] : trial[ddo_pkg::DVSR_W-1:0];
			quo_q <= {quo_q[ddo_pkg::DIV_W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one step per cycle, gives cos and sin in Q30.
// ----------------------------------------------------------------------------
module ddo_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ddo_pkg::ANG_W-1:0]           angle,
	output logic signed [ddo_pkg::TRIG_W-1:0]   cos_out,
	output logic signed [ddo_pkg::TRIG_W-1:0]   sin_out,
	output logic                                busy
);

	localparam logic [4:0] LAST = 5'(ddo_pkg::CORDIC_STEPS - 1);

	logic                                busy_q;
	logic [4:0]                          i_q;
	logic [1:0]                          quad_q;
	logic signed [ddo_pkg::TRIG_W-1:0]   x_q;
	logic signed [ddo_pkg::TRIG_W-1:0]   y_q;
	logic signed [ddo_pkg::ANG_W-1:0]    z_q;
	logic signed [ddo_pkg::TRIG_W-1:0]   xs;
	logic signed [ddo_pkg::TRIG_W-1:0]   ys;
	logic signed [ddo_pkg::ANG_W-1:0]    at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = signed'(ddo_pkg::atan_entry(i_q));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// micro-rotation toward zero residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ddo_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= signed'({2'b00, angle[ddo_pkg::ANG_W-3:0]});
			quad_q <= angle[ddo_pkg::ANG_W-1:ddo_pkg::ANG_W-2];
		end else if (busy_q) begin
			if (!z_q[ddo_pkg::ANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant fold
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_out = x_q;
				sin_out = y_q;
			end
			2'd1: begin
				cos_out = -y_q;
				sin_out = x_q;
			end
			2'd2: begin
				cos_out = -x_q;
				sin_out = -y_q;
			end
			default: begin
				cos_out = y_q;
				sin_out = -x_q;
			end
		endcase
	end

	assign busy = busy_q;

endmodule
